// ===== rtl/tti_pkg.sv =====
// Package for the thermistor table interpolator: widths, the voltage and
// temperature ROM, and per-segment slope tables. No dependencies.
package tti_pkg;

  localparam int ROM_ROWS     = 13;
  localparam int SEG_COUNT    = ROM_ROWS - 1;
  localparam int TABLE_ROWS_D = 13;

  localparam int MV_W   = 12;
  localparam int TEMP_W = 14;
  localparam int K_W    = $clog2(ROM_ROWS + 1);
  localparam int SEG_W  = $clog2(SEG_COUNT);
  localparam int DX_W   = 7;   // segment voltage span, at most 122 mV
  localparam int QS_W   = 6;   // whole slope per mV, at most 33
  localparam int REM_W  = 14;  // remainder times offset, below 122 * 122
  localparam int DIV_BITS = 7; // fractional quotient stays below 128

  localparam logic [MV_W-1:0] ROM_MV [ROM_ROWS] = '{
    12'd1650, 12'd1590, 12'd1559, 12'd1516, 12'd1459, 12'd1386, 12'd1297,
    12'd1193, 12'd1079, 12'd957,  12'd836,  12'd718,  12'd630
  };

  localparam logic [TEMP_W-1:0] ROM_TEMP [ROM_ROWS] = '{
    14'd0,    14'd2000, 14'd3000, 14'd4000,  14'd5000,  14'd6000, 14'd7000,
    14'd8000, 14'd9000, 14'd10000, 14'd11000, 14'd12000, 14'd12800
  };

  // Segment i spans rows i and i+1: span = mv[i] - mv[i+1],
  // temperature step = slope * span + rem, with rem < span.
  localparam logic [DX_W-1:0] SEG_SPAN [SEG_COUNT] = '{
    7'd60, 7'd31, 7'd43, 7'd57, 7'd73, 7'd89,
    7'd104, 7'd114, 7'd122, 7'd121, 7'd118, 7'd88
  };

  localparam logic [QS_W-1:0] SEG_SLOPE [SEG_COUNT] = '{
    6'd33, 6'd32, 6'd23, 6'd17, 6'd13, 6'd11,
    6'd9,  6'd8,  6'd8,  6'd8,  6'd8,  6'd9
  };

  localparam logic [DX_W-1:0] SEG_REM [SEG_COUNT] = '{
    7'd20, 7'd8,  7'd11, 7'd31, 7'd51, 7'd21,
    7'd64, 7'd88, 7'd24, 7'd32, 7'd56, 7'd8
  };

endpackage

// ===== rtl/thermistor_table_interpolator_core.sv =====
// Thermistor table interpolator top level: ROM search, slope lookup,
// multiply and a pipelined restoring divider. Depends on tti_pkg.
//
// Usage:
//   Input channel: drive in_sense_mv (millivolts) and raise start; the beat
//   is taken at every rising edge where start is high and busy is low.
//   busy is always low, so a new sample may be offered on every cycle.
//   Result channel: out_valid is high for exactly one cycle with
//   out_temperature, one result per accepted sample, in input order.
//   Throughput: one sample per cycle. The depth is set by the seven one-bit
//   stages of the divider that resolves the fractional part of the slope,
//   plus search, lookup, multiply and final add stages.
//   Reset (rst_n low, synchronous) clears all valid bits; samples in flight
//   are dropped and no result appears for them.
//   The receiver cannot stall; results are never held back.
//   TABLE_ROWS (2..13) selects how many leading ROM rows are searched.
module thermistor_table_interpolator_core
  import tti_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MV_W-1:0]   in_sense_mv,
  output logic              out_valid,
  output logic [TEMP_W-1:0] out_temperature
);

  localparam int LATENCY = 3 + DIV_BITS + 1;
  localparam logic [K_W-1:0] ROWS_K = K_W'(TABLE_ROWS);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: row search ----------------
  logic [K_W-1:0]  k_nxt;
  logic            s1_valid_r;
  logic [MV_W-1:0] s1_mv_r;
  logic [K_W-1:0]  s1_k_r;

  // rows fall in voltage, so the count of rows above the input is the index
  always_comb begin
    k_nxt = '0;
    for (int i = 0; i < TABLE_ROWS; i++) begin
      if (in_sense_mv < ROM_MV[i]) k_nxt = k_nxt + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_mv_r <= in_sense_mv;
    s1_k_r  <= k_nxt;
  end

  // ---------------- stage 2: segment lookup ----------------
  logic               interp;
  logic [K_W-1:0]     row_hi;
  logic [SEG_W-1:0]   seg_idx;
  logic [MV_W-1:0]    dx_full;
  logic [TEMP_W-1:0]  base_nxt;
  logic               s2_valid_r;
  logic [TEMP_W-1:0]  s2_base_r;
  logic [QS_W-1:0]    s2_slope_r;
  logic [DX_W-1:0]    s2_rem_r;
  logic [DX_W-1:0]    s2_span_r;
  logic [DX_W-1:0]    s2_dx_r;

  always_comb begin
    interp  = (s1_k_r != '0) && (s1_k_r < ROWS_K);
    row_hi  = (s1_k_r == '0) ? '0 : s1_k_r - K_W'(1);
    seg_idx = (row_hi > K_W'(SEG_COUNT - 1)) ? SEG_W'(SEG_COUNT - 1)
                                             : row_hi[SEG_W-1:0];
    dx_full = ROM_MV[row_hi] - s1_mv_r;
    if (interp) begin
      base_nxt = ROM_TEMP[row_hi];
    end else if (s1_k_r == '0) begin
      base_nxt = ROM_TEMP[0];
    end else begin
      base_nxt = ROM_TEMP[TABLE_ROWS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_base_r  <= base_nxt;
    s2_slope_r <= interp ? SEG_SLOPE[seg_idx] : '0;
    s2_rem_r   <= interp ? SEG_REM[seg_idx] : '0;
    s2_span_r  <= interp ? SEG_SPAN[seg_idx] : DX_W'(1);
    s2_dx_r    <= interp ? dx_full[DX_W-1:0] : '0;
  end

  // ---------------- stage 3: multiply ----------------
  // div_*_r[0] is the multiply output; entry s+1 follows divider step s
  logic              div_valid_r [DIV_BITS+1];
  logic [TEMP_W-1:0] div_base_r  [DIV_BITS+1];
  logic [REM_W-1:0]  div_num_r   [DIV_BITS+1];
  logic [DX_W-1:0]   div_span_r  [DIV_BITS+1];
  logic [DIV_BITS-1:0] div_quo_r [DIV_BITS+1];

  logic [TEMP_W-1:0] whole_step;
  logic [REM_W-1:0]  frac_num;

  assign whole_step = TEMP_W'(s2_slope_r) * TEMP_W'(s2_dx_r);
  assign frac_num   = REM_W'(s2_rem_r) * REM_W'(s2_dx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r[0] <= 1'b0;
    end else begin
      div_valid_r[0] <= s2_valid_r;
    end
    div_base_r[0] <= s2_base_r + whole_step;
    div_num_r[0]  <= frac_num;
    div_span_r[0] <= s2_span_r;
    div_quo_r[0]  <= '0;
  end

  // ---------------- stages 4..: restoring divider, one bit each ----------------
  for (genvar s = 0; s < DIV_BITS; s++) begin : g_div
    localparam int BIT = DIV_BITS - 1 - s;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign trial = REM_W'(div_span_r[s]) << BIT;
    assign fits  = div_num_r[s] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_valid_r[s+1] <= 1'b0;
      end else begin
        div_valid_r[s+1] <= div_valid_r[s];
      end
      div_base_r[s+1] <= div_base_r[s];
      div_span_r[s+1] <= div_span_r[s];
      div_num_r[s+1]  <= fits ? div_num_r[s] - trial : div_num_r[s];
      div_quo_r[s+1]  <= div_quo_r[s] | (DIV_BITS'(fits) << BIT);
    end
  end

  // ---------------- output register ----------------
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_temperature_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid_r[DIV_BITS];
    end
    out_temperature_r <= div_base_r[DIV_BITS] + TEMP_W'(div_quo_r[DIV_BITS]);
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temperature_r;

  // ---------------- assertions ----------------
  a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted beat produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching input beat");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid_r[DIV_BITS] |-> (div_num_r[DIV_BITS] < REM_W'(div_span_r[DIV_BITS])))
    else $error("divider remainder not reduced below span");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature <= ROM_TEMP[ROM_ROWS-1]))
    else $error("temperature above table range");

endmodule

// ===== verif/thermistor_table_interpolator_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for thermistor_table_interpolator_core: drives voltage beats,
// predicts each temperature from the package ROM and checks results in order.
// Depends on tti_pkg and the core RTL.
module thermistor_table_interpolator_core_test;
  import tti_pkg::*;

  localparam int ROWS_USED = TABLE_ROWS_D;
  localparam int LATENCY   = 11;

  typedef logic [MV_W-1:0]   mv_t;
  typedef logic [TEMP_W-1:0] temp_t;

  // Holds predicted temperatures in input order and checks results against them.
  class temp_scoreboard;
    temp_t expected_temps[$];
    int    rows;
    int    errors;

    function new(int table_rows);
      rows = table_rows;
      if (rows > ROM_ROWS) rows = ROM_ROWS;
      if (rows < 1) rows = 1;
      errors = 0;
    endfunction

    // Piecewise-linear lookup; int division truncates toward zero as required.
    function temp_t interp_temperature(mv_t mv);
      int k, t_hi, v_hi, dt, dv, dx, q, r, t;
      k = 0;
      while (k < rows && int'(mv) < int'(ROM_MV[k])) k++;
      if (k == 0) begin
        t = int'(ROM_TEMP[0]);
      end else if (k >= rows) begin
        t = int'(ROM_TEMP[rows-1]);
      end else begin
        t_hi = int'(ROM_TEMP[k-1]);
        v_hi = int'(ROM_MV[k-1]);
        dt   = int'(ROM_TEMP[k]) - t_hi;
        dv   = int'(ROM_MV[k]) - v_hi;
        if (dv == 0) begin
          t = t_hi;
        end else begin
          dx = int'(mv) - v_hi;
          q  = dt / dv;
          r  = dt % dv;
          t  = t_hi + q * dx + (r * dx) / dv;
        end
      end
      return TEMP_W'(t);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function void note_sample(mv_t mv);
      expected_temps.push_back(interp_temperature(mv));
    endfunction

    task check_result(temp_t temp);
      temp_t want;
      if (expected_temps.size() == 0) begin
        report($sformatf("unexpected result temperature=%0d", temp));
      end else begin
        want = expected_temps.pop_front();
        if (temp !== want)
          report($sformatf("temperature got %0d want %0d", temp, want));
      end
    endtask

    function int pending();
      return expected_temps.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  mv_t   in_sense_mv = '0;
  logic  out_valid;
  temp_t out_temperature;

  temp_scoreboard sb = new(ROWS_USED);

  thermistor_table_interpolator_core #(.TABLE_ROWS(ROWS_USED)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sense_mv     (in_sense_mv),
    .out_valid       (out_valid),
    .out_temperature (out_temperature)
  );

  always #6 clk = ~clk;

  // Beat monitor: DUT outputs change via NBA, so pre-edge values are seen here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_sample(in_sense_mv);
      if (out_valid) sb.check_result(out_temperature);
    end
  end

  task automatic send_sample(input mv_t mv, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      in_sense_mv <= mv_t'($urandom);
      @(negedge clk);
    end
    start       <= 1'b1;
    in_sense_mv <= mv;
    do @(posedge clk); while (busy);
  endtask

  // Sender holds off until every predicted temperature has been returned.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic mv_t pick_voltage();
    int sel, row;
    sel = $urandom_range(99);
    if (sel < 65) return mv_t'($urandom_range(1700, 600));
    if (sel < 80) begin
      row = $urandom_range(ROM_ROWS - 1);
      return mv_t'(int'(ROM_MV[row]) + $urandom_range(4) - 2);
    end
    return mv_t'($urandom);
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    repeat (count) send_sample(pick_voltage(), idle_pct);
  endtask

  initial begin
    mv_t directed[$];
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // extremes, above the top row, every row voltage, around the bottom row
    directed = '{12'd0, 12'd4095, 12'd1651, 12'd1649, 12'd629, 12'd631, 12'd2048,
                 12'd1024, 12'd2730, 12'd1365};
    for (int i = 0; i < ROM_ROWS; i++) directed.push_back(ROM_MV[i]);
    foreach (directed[i]) send_sample(directed[i], 0);
    wait_drained();

    run_random(650, 30);
    wait_drained();
    run_random(650, 45);
    wait_drained();
    run_random(650, 0);
    wait_drained();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== thermistor_table_interpolator_core.f =====
rtl/tti_pkg.sv
rtl/thermistor_table_interpolator_core.sv
verif/thermistor_table_interpolator_core_test.sv
